// ===== hdl/msra_pkg.sv =====
package msra_pkg;

  localparam int CMD_W      = 2;
  localparam int SET_W      = 2;
  localparam int CELL_W     = 10;
  localparam int REGION_W   = 6;
  localparam int VALUE_W    = 32;
  localparam int BIN_W      = 48;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 3;
  localparam int SET_FW     = 4;

  localparam int DEF_NUM_SETS    = 4;
  localparam int DEF_NUM_CELLS   = 1024;
  localparam int DEF_NUM_BINS    = 64;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] SETS_RESET = 3'd1;

  localparam logic signed [BIN_W-1:0] BIN_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [BIN_W-1:0] BIN_MIN = 48'sh8000_0000_0000;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_MAP_WRITE = 2'd1,
    CMD_ADD       = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_NOTE  = 2'd1,
    OP_ADD   = 2'd2,
    OP_READ  = 2'd3
  } op_kind_t;

  typedef enum logic {
    F_IDLE   = 1'b0,
    F_LOOKUP = 1'b1
  } fstate_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [SET_FW-1:0]     set_sel;
    logic [REGION_W-1:0]   region;
    logic [VALUE_W-1:0]    value;
    logic                  err;
    logic                  last;
  } op_t;

endpackage

// ===== hdl/msra_chan_if.sv =====
interface msra_in_if;
  import msra_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [SET_W-1:0]           set_index;
  logic [CELL_W-1:0]          cell_index;
  logic [REGION_W-1:0]        region_id;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, command, set_index, cell_index, region_id, value,
                  input ready);
  modport sink (input valid, command, set_index, cell_index, region_id, value,
                output ready);
endinterface

interface msra_out_if;
  import msra_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [BIN_W-1:0]    bin_value;
  logic [STATUS_W-1:0]        status;
  logic                       last;

  modport source (output valid, bin_value, status, last, input ready);
  modport sink (input valid, bin_value, status, last, output ready);
endinterface

// ===== hdl/multi_set_region_accumulator.sv =====
// Path: an accepted beat passes the front, op queue, back-end stage and result register.
// Throughput: one beat per cycle for clear, map write and read items while the queue
// has room; an add holds the front for one region map read per set in use.
// One bin read-modify-write per cycle unless result stalls, forwarding back-to-back hits.
// Reset: synchronous; bins read as zero at once, sets_in_use returns to 1,
// region map keeps no reset value and must be written before use.
module multi_set_region_accumulator #(
  parameter int NUM_SETS    = msra_pkg::DEF_NUM_SETS,
  parameter int NUM_CELLS   = msra_pkg::DEF_NUM_CELLS,
  parameter int NUM_BINS    = msra_pkg::DEF_NUM_BINS,
  parameter int QUEUE_DEPTH = msra_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  msra_in_if.sink                     item,
  msra_out_if.source                  result,
  input  logic                        cfg_wr_en,
  input  logic [msra_pkg::CFG_W-1:0]  cfg_wr_data
);
  import msra_pkg::*;

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  op_t  push_op;
  op_t  q_op;

  msra_front #(
    .NUM_SETS  (NUM_SETS),
    .NUM_CELLS (NUM_CELLS),
    .NUM_BINS  (NUM_BINS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .push_op     (push_op)
  );

  msra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .head    (q_op)
  );

  msra_back #(
    .NUM_SETS (NUM_SETS),
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== hdl/msra_front.sv =====
module msra_front #(
  parameter int NUM_SETS  = msra_pkg::DEF_NUM_SETS,
  parameter int NUM_CELLS = msra_pkg::DEF_NUM_CELLS,
  parameter int NUM_BINS  = msra_pkg::DEF_NUM_BINS
) (
  input  logic                        clk,
  input  logic                        rst,
  msra_in_if.sink                     item,
  input  logic                        cfg_wr_en,
  input  logic [msra_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        q_full,
  output logic                        push,
  output msra_pkg::op_t               push_op
);
  import msra_pkg::*;

  localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int MAP_DEPTH = 1 << (SET_AW + CELL_AW);

  fstate_t state, state_next;

  logic [CFG_W-1:0]          sets_cfg;
  logic [CFG_W-1:0]          n_cur;
  logic [CFG_W-1:0]          n_reg;
  logic [CFG_W-1:0]          s_cnt;
  logic [CFG_W-1:0]          s_inc;
  logic [CELL_AW-1:0]        cell_reg;
  logic [VALUE_W-1:0]        value_reg;

  logic [REGION_W-1:0]       map_mem [MAP_DEPTH];
  logic [REGION_W-1:0]       map_q;
  logic                      map_we;
  logic                      map_re;
  logic [SET_AW+CELL_AW-1:0] map_waddr;
  logic [SET_AW+CELL_AW-1:0] map_raddr;

  logic                      accept;
  logic                      set_ok;
  logic                      cell_ok;
  logic                      reg_ok;
  logic                      map_ok;
  logic [CELL_AW-1:0]        cell_a;
  cmd_t                      cmd;

  assign item.ready = (state == F_IDLE) && !q_full;
  assign accept     = item.valid && item.ready;
  assign cmd        = cmd_t'(item.command);
  assign cell_a     = CELL_AW'(item.cell_index);
  assign set_ok     = 32'(item.set_index) < 32'(NUM_SETS);
  assign cell_ok    = 32'(item.cell_index) < 32'(NUM_CELLS);
  assign reg_ok     = 32'(item.region_id) < 32'(NUM_BINS);
  assign map_ok     = 32'(map_q) < 32'(NUM_BINS);
  assign n_cur      = (32'(sets_cfg) > 32'(NUM_SETS)) ? CFG_W'(NUM_SETS) : sets_cfg;
  assign s_inc      = s_cnt + 3'd1;
  assign map_waddr  = {SET_AW'(item.set_index), cell_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      sets_cfg <= SETS_RESET;
    end else if (cfg_wr_en) begin
      sets_cfg <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      s_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        s_cnt <= '0;
      end else if (state == F_LOOKUP && push) begin
        s_cnt <= s_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_reg     <= n_cur;
      cell_reg  <= cell_a;
      value_reg <= item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= item.region_id;
    end
    if (map_re) begin
      map_q <= map_mem[map_raddr];
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_op    = '0;
    map_we     = 1'b0;
    map_re     = 1'b0;
    map_raddr  = {SET_AW'(s_inc), cell_reg};
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          push_op.last    = 1'b1;
          push_op.set_sel = SET_FW'(item.set_index);
          push_op.region  = item.region_id;
          unique case (cmd)
            CMD_CLEAR: begin
              push         = 1'b1;
              push_op.kind = OP_CLEAR;
            end
            CMD_MAP_WRITE: begin
              push         = 1'b1;
              push_op.kind = OP_NOTE;
              push_op.err  = !(set_ok && cell_ok && reg_ok);
              map_we       = set_ok && cell_ok;
            end
            CMD_ADD: begin
              if (!cell_ok || n_cur == '0) begin
                push         = 1'b1;
                push_op.kind = OP_NOTE;
                push_op.err  = !cell_ok;
              end else begin
                map_re     = 1'b1;
                map_raddr  = {SET_AW'(0), cell_a};
                state_next = F_LOOKUP;
              end
            end
            CMD_READ: begin
              push         = 1'b1;
              push_op.kind = OP_READ;
              push_op.err  = !(set_ok && reg_ok);
            end
            default: begin
              push = 1'b0;
            end
          endcase
        end
      end
      F_LOOKUP: begin
        if (!q_full) begin
          push            = 1'b1;
          push_op.kind    = OP_ADD;
          push_op.set_sel = SET_FW'(s_cnt);
          push_op.region  = map_q;
          push_op.value   = value_reg;
          push_op.err     = !map_ok;
          push_op.last    = (s_inc == n_reg);
          if (s_inc == n_reg) begin
            state_next = F_IDLE;
          end else begin
            map_re = 1'b1;
          end
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == F_LOOKUP) |-> (s_cnt < n_reg))
    else $error("set counter beyond sets in use");

  a_lookup_ends: assert property (@(posedge clk) disable iff (rst)
    (state == F_LOOKUP && push && s_inc == n_reg) |=> (state == F_IDLE))
    else $error("lookup did not end after final set");
`endif

endmodule

// ===== hdl/msra_queue.sv =====
module msra_queue #(
  parameter int DEPTH = msra_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  msra_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output msra_pkg::op_t  head
);
  import msra_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");
`endif

endmodule

// ===== hdl/msra_back.sv =====
module msra_back #(
  parameter int NUM_SETS = msra_pkg::DEF_NUM_SETS,
  parameter int NUM_BINS = msra_pkg::DEF_NUM_BINS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  msra_pkg::op_t  q_op,
  output logic           pop,
  msra_out_if.source     result
);
  import msra_pkg::*;

  localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int BIN_AW    = $clog2(NUM_BINS);
  localparam int BIN_DEPTH = 1 << (SET_AW + BIN_AW);

  logic signed [BIN_W-1:0]  bin_mem [BIN_DEPTH];
  logic [BIN_DEPTH-1:0]     bin_vld;

  op_t                      st;
  logic                     st_valid;
  logic                     st_advance;
  logic [SET_AW+BIN_AW-1:0] st_addr;
  logic [SET_AW+BIN_AW-1:0] q_addr;

  logic signed [BIN_W-1:0]  rd_data;
  logic                     rd_vld;
  logic                     byp_hit;
  logic                     byp_zero;
  logic signed [BIN_W-1:0]  byp_data;

  logic signed [BIN_W-1:0]  cur;
  logic signed [BIN_W:0]    sum_wide;
  logic                     ovf;
  logic signed [BIN_W-1:0]  new_bin;
  logic                     bin_we;
  logic                     clear_now;
  logic                     finish;

  logic                     range_acc;
  logic                     sat_acc;
  logic                     range_any;
  logic                     sat_any;

  logic                     out_valid;
  logic signed [BIN_W-1:0]  out_value;
  logic [STATUS_W-1:0]      out_status;
  logic signed [BIN_W-1:0]  res_value;
  logic [STATUS_W-1:0]      res_status;

  assign q_addr     = {SET_AW'(q_op.set_sel), BIN_AW'(q_op.region)};
  assign st_advance = !st.last || !out_valid || result.ready;
  assign pop        = q_valid && (!st_valid || st_advance);
  assign finish     = st_valid && st_advance && st.last;

  assign cur      = byp_zero ? '0 : (byp_hit ? byp_data : (rd_vld ? rd_data : '0));
  assign sum_wide = {cur[BIN_W-1], cur} + {{(BIN_W + 1 - VALUE_W){st.value[VALUE_W-1]}}, st.value};
  assign ovf      = sum_wide[BIN_W] ^ sum_wide[BIN_W-1];
  assign new_bin  = ovf ? (sum_wide[BIN_W] ? BIN_MIN : BIN_MAX) : sum_wide[BIN_W-1:0];

  assign bin_we    = st_valid && st_advance && (st.kind == OP_ADD) && !st.err;
  assign clear_now = st_valid && st_advance && (st.kind == OP_CLEAR);

  assign range_any = range_acc || st.err;
  assign sat_any   = sat_acc || (ovf && !st.err);

  always_comb begin
    res_value  = '0;
    res_status = STATUS_OK;
    unique case (st.kind)
      OP_CLEAR: begin
        res_status = STATUS_OK;
      end
      OP_NOTE: begin
        res_status = st.err ? STATUS_RANGE : STATUS_OK;
      end
      OP_READ: begin
        res_status = st.err ? STATUS_RANGE : STATUS_OK;
        res_value  = st.err ? '0 : cur;
      end
      OP_ADD: begin
        res_status = range_any ? STATUS_RANGE : (sat_any ? STATUS_SAT : STATUS_OK);
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (pop) begin
      st_valid <= 1'b1;
    end else if (st_advance) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      st       <= q_op;
      st_addr  <= q_addr;
      rd_vld   <= bin_vld[q_addr];
      byp_hit  <= bin_we && (st_addr == q_addr);
      byp_zero <= clear_now;
      byp_data <= new_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[st_addr] <= new_bin;
    end
    if (pop) begin
      rd_data <= bin_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_now) begin
      bin_vld <= '0;
    end else if (bin_we) begin
      bin_vld[st_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_acc <= 1'b0;
      sat_acc   <= 1'b0;
    end else if (st_valid && st_advance && st.kind == OP_ADD) begin
      if (st.last) begin
        range_acc <= 1'b0;
        sat_acc   <= 1'b0;
      end else begin
        range_acc <= range_any;
        sat_acc   <= sat_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign result.valid     = out_valid;
  assign result.bin_value = out_value;
  assign result.status    = out_status;
  assign result.last      = 1'b1;

`ifndef NO_ASSERTIONS
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (st_valid && !st_advance) |=> (st_valid && $stable(st) && $stable(st_addr)))
    else $error("stalled stage changed");

  a_flags_cleared: assert property (@(posedge clk) disable iff (rst)
    (finish && st.kind == OP_ADD) |=> (!range_acc && !sat_acc))
    else $error("item flags leaked into next item");
`endif

endmodule
